// File: hw/rtl/ffdx_pkg.sv
// ----------------------------------------------------------------------------
// ffdx_pkg - shared types and constants of the fixed frame deframer
// Register indexes, reset values, frame positions and result types.
// ----------------------------------------------------------------------------
package ffdx_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned ANGLE_W       = 16;
    localparam int unsigned OUT_COUNT_W   = 32;
    localparam int unsigned COUNT_W_DEF   = 32;
    localparam int unsigned CFG_INDEX_W   = 8;
    localparam int unsigned POS_W         = 4;
    localparam int unsigned TDATA_BITS    = 2 * ANGLE_W + 1 + 2 * OUT_COUNT_W;
    localparam int unsigned M_TDATA_W     = ((TDATA_BITS + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_FIRST  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SECOND = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_CODE   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GYRO_CODE     = 8'd3;

    localparam logic [BYTE_W-1:0] RST_HEADER_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] RST_HEADER_SECOND = 8'h55;
    localparam logic [BYTE_W-1:0] RST_LENGTH_CODE   = 8'd6;
    localparam logic [BYTE_W-1:0] RST_GYRO_CODE     = 8'd1;

    // byte positions inside the frame
    localparam logic [POS_W-1:0] POS_IDLE    = 4'd0;
    localparam logic [POS_W-1:0] POS_LEN     = 4'd2;
    localparam logic [POS_W-1:0] POS_PAN_HI  = 4'd3;
    localparam logic [POS_W-1:0] POS_PAN_LO  = 4'd4;
    localparam logic [POS_W-1:0] POS_TILT_HI = 4'd5;
    localparam logic [POS_W-1:0] POS_TILT_LO = 4'd6;
    localparam logic [POS_W-1:0] POS_MODE    = 4'd7;
    localparam logic [POS_W-1:0] POS_CHECK   = 4'd8;

    typedef enum logic [2:0] {
        ST_HUNT1 = 3'b001,
        ST_HUNT2 = 3'b010,
        ST_BODY  = 3'b100
    } state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [BYTE_W-1:0] length_code;
        logic [BYTE_W-1:0] gyro_code;
    } cfg_t;

    typedef struct packed {
        logic                   frame_good;
        logic [ANGLE_W-1:0]     pan_tenths;
        logic [ANGLE_W-1:0]     tilt_tenths;
        logic                   gyro_mode;
        logic [OUT_COUNT_W-1:0] good_frames;
        logic [OUT_COUNT_W-1:0] bad_frames;
    } res_t;

endpackage

// File: hw/rtl/ffdx_cfg.sv
// ----------------------------------------------------------------------------
// ffdx_cfg - configuration registers
// Header bytes, expected length and gyro mode code, written by index.
// ----------------------------------------------------------------------------
module ffdx_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ffdx_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ffdx_pkg::BYTE_W-1:0]       cfg_data,
    output ffdx_pkg::cfg_t                    cfg
);
    import ffdx_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_HEADER_FIRST:  cfg_next.header_first  = cfg_data;
                CFG_HEADER_SECOND: cfg_next.header_second = cfg_data;
                CFG_LENGTH_CODE:   cfg_next.length_code   = cfg_data;
                CFG_GYRO_CODE:     cfg_next.gyro_code     = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_first  <= RST_HEADER_FIRST;
            cfg_reg.header_second <= RST_HEADER_SECOND;
            cfg_reg.length_code   <= RST_LENGTH_CODE;
            cfg_reg.gyro_code     <= RST_GYRO_CODE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/ffdx_parse.sv
// ----------------------------------------------------------------------------
// ffdx_parse - header hunt, frame collection and check
// Tracks the frame position, keeps a running xor over the body and
// produces the result of a completed frame in the cycle of its last byte.
// ----------------------------------------------------------------------------
module ffdx_parse #(
    parameter int unsigned COUNT_WIDTH = ffdx_pkg::COUNT_W_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         byte_accept,
    input  logic [ffdx_pkg::BYTE_W-1:0]  rx_byte,
    input  ffdx_pkg::cfg_t               cfg,
    output logic                         res_valid,
    output ffdx_pkg::res_t               res
);
    import ffdx_pkg::*;

    state_t               state_reg,  state_next;
    logic [POS_W-1:0]     pos_reg,    pos_next;
    logic [BYTE_W-1:0]    xor_reg,    xor_next;
    logic [BYTE_W-1:0]    len_reg,    len_next;
    logic [ANGLE_W-1:0]   pan_reg,    pan_next;
    logic [ANGLE_W-1:0]   tilt_reg,   tilt_next;
    logic [BYTE_W-1:0]    mode_reg,   mode_next;
    logic [ANGLE_W-1:0]   last_pan_reg,  last_pan_next;
    logic [ANGLE_W-1:0]   last_tilt_reg, last_tilt_next;
    logic                 last_gyro_reg, last_gyro_next;
    logic [COUNT_WIDTH-1:0] good_cnt_reg, good_cnt_next;
    logic [COUNT_WIDTH-1:0] bad_cnt_reg,  bad_cnt_next;
    logic                 frame_ok;

    assign frame_ok = (len_reg == cfg.length_code) && (xor_reg == rx_byte);

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        xor_next       = xor_reg;
        len_next       = len_reg;
        pan_next       = pan_reg;
        tilt_next      = tilt_reg;
        mode_next      = mode_reg;
        last_pan_next  = last_pan_reg;
        last_tilt_next = last_tilt_reg;
        last_gyro_next = last_gyro_reg;
        good_cnt_next  = good_cnt_reg;
        bad_cnt_next   = bad_cnt_reg;
        res_valid      = 1'b0;
        if (byte_accept) begin
            case (state_reg)
                ST_HUNT1: begin
                    if (rx_byte == cfg.header_first) begin
                        state_next = ST_HUNT2;
                    end
                end
                ST_HUNT2: begin
                    if (rx_byte == cfg.header_second) begin
                        state_next = ST_BODY;
                        pos_next   = POS_LEN;
                        xor_next   = '0;
                    end else if (rx_byte != cfg.header_first) begin
                        state_next = ST_HUNT1;
                    end
                end
                ST_BODY: begin
                    pos_next = pos_reg + 1'b1;
                    xor_next = xor_reg ^ rx_byte;
                    case (pos_reg)
                        POS_LEN:     len_next          = rx_byte;
                        POS_PAN_HI:  pan_next[15:8]    = rx_byte;
                        POS_PAN_LO:  pan_next[7:0]     = rx_byte;
                        POS_TILT_HI: tilt_next[15:8]   = rx_byte;
                        POS_TILT_LO: tilt_next[7:0]    = rx_byte;
                        POS_MODE:    mode_next         = rx_byte;
                        POS_CHECK: begin
                            // frame complete
                            state_next = ST_HUNT1;
                            pos_next   = POS_IDLE;
                            res_valid  = 1'b1;
                            if (frame_ok) begin
                                last_pan_next  = pan_reg;
                                last_tilt_next = tilt_reg;
                                last_gyro_next = (mode_reg == cfg.gyro_code);
                                good_cnt_next  = good_cnt_reg + 1'b1;
                            end else begin
                                bad_cnt_next   = bad_cnt_reg + 1'b1;
                            end
                        end
                        default: begin
                            state_next = ST_HUNT1;
                            pos_next   = POS_IDLE;
                        end
                    endcase
                end
                default: begin
                    state_next = ST_HUNT1;
                    pos_next   = POS_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        res.frame_good  = frame_ok;
        res.pan_tenths  = last_pan_next;
        res.tilt_tenths = last_tilt_next;
        res.gyro_mode   = last_gyro_next;
        res.good_frames = OUT_COUNT_W'(good_cnt_next);
        res.bad_frames  = OUT_COUNT_W'(bad_cnt_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_HUNT1;
            pos_reg       <= POS_IDLE;
            last_pan_reg  <= '0;
            last_tilt_reg <= '0;
            last_gyro_reg <= 1'b0;
            good_cnt_reg  <= '0;
            bad_cnt_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            last_pan_reg  <= last_pan_next;
            last_tilt_reg <= last_tilt_next;
            last_gyro_reg <= last_gyro_next;
            good_cnt_reg  <= good_cnt_next;
            bad_cnt_reg   <= bad_cnt_next;
        end
    end

    // body bytes, no reset needed
    always_ff @(posedge aclk) begin
        xor_reg  <= xor_next;
        len_reg  <= len_next;
        pan_reg  <= pan_next;
        tilt_reg <= tilt_next;
        mode_reg <= mode_next;
    end

endmodule

// File: hw/rtl/ffdx_out.sv
// ----------------------------------------------------------------------------
// ffdx_out - result output register
// Holds one result word until the receiver takes it and packs the stream.
// ----------------------------------------------------------------------------
module ffdx_out (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  ffdx_pkg::res_t                  res,
    output logic                            space,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ffdx_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tuser
);
    import ffdx_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    assign space = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.frame_good;
    assign m_tdata  = M_TDATA_W'({res_reg.bad_frames, res_reg.good_frames, res_reg.gyro_mode,
                                  res_reg.tilt_tenths, res_reg.pan_tenths});

endmodule

// File: hw/rtl/fixed_frame_deframer_xor_unit.sv
// ----------------------------------------------------------------------------
// fixed_frame_deframer_xor_unit - two byte header frame receiver, xor check
// Receives bytes on the s_ stream, hunts for the two header bytes and
// collects a fixed nine byte frame of length, pan, tilt, mode and check.
// Every completed frame gives one word on the m_ stream with the check
// result in m_tuser and the last good pan, tilt, mode and the good and
// bad frame counters in m_tdata; other bytes give no word.
// One byte is taken every cycle while the output register is free or
// being emptied; a result word appears in the cycle after the frame's last
// byte. The output register is the only buffer: while the receiver
// stalls and a word waits, s_tready is low.
// The cfg_ channel writes header bytes, length code and gyro code by index;
// it is always ready; the user must write it between frames, the block does not enforce it.
// Reset (aresetn low, synchronous) restarts the header hunt, clears the
// counters and the last good values and restores the register defaults.
// ----------------------------------------------------------------------------
module fixed_frame_deframer_xor_unit #(
    parameter int unsigned COUNT_WIDTH = ffdx_pkg::COUNT_W_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // rx_byte
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,
    // pan_tenths, tilt_tenths, gyro_mode, good_frames, bad_frames
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ffdx_pkg::M_TDATA_W-1:0]    m_tdata,
    // frame_good
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ffdx_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ffdx_pkg::BYTE_W-1:0]       cfg_data
);
    import ffdx_pkg::*;

    cfg_t cfg;
    res_t res;
    logic res_valid;
    logic space;
    logic byte_accept;

    assign s_tready    = space;
    assign byte_accept = s_tvalid && space;

    ffdx_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ffdx_parse #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_tdata),
        .cfg         (cfg),
        .res_valid   (res_valid),
        .res         (res)
    );

    ffdx_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res      (res),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // a new result word only follows an accepted byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && $past(!m_tvalid || m_tready) |-> $past(s_tvalid && s_tready))
        else $error("result word without an accepted byte");

    // input stalls only behind a waiting word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with a free output register");

    // a result is produced only on an accepted byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> byte_accept)
        else $error("result without an accepted byte");

endmodule
